// ===== design/mfbt_pkg.sv =====
package mfbt_pkg;

  localparam int MFBT_MOTORS_PER_BUS = 4;
  localparam int MFBT_BUSES = 2;

  localparam logic [10:0] ID_BASE = 11'h141;
  localparam logic [15:0] HALF_TURN_RESET = 16'd32768;
  localparam logic [15:0] STALE_TICKS_RESET = 16'd10;

  // Register index as decoded from paddr[2].
  localparam logic REG_HALF_TURN = 1'b0;
  localparam logic REG_STALE_TICKS = 1'b1;

  localparam logic FUNC_FEEDBACK = 1'b0;
  localparam logic FUNC_ZERO = 1'b1;

  typedef struct packed {
    logic               func;
    logic               bus;
    logic [10:0]        can_id;
    logic [31:0]        now_tick;
    logic [7:0]         temp_byte;
    logic signed [15:0] current_raw;
    logic signed [15:0] speed_raw;
    logic [15:0]        angle_raw;
  } item_t;

  typedef struct packed {
    logic [15:0]        pos;
    logic signed [15:0] vel;
    logic signed [15:0] amps;
    logic [7:0]         temp;
    logic signed [15:0] turns;
    logic [15:0]        zero;
    logic [31:0]        stamp;
  } entry_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         motor_slot;
    logic               was_reset;
    logic [15:0]        pos_now;
    logic signed [15:0] vel_now;
    logic signed [15:0] amps_now;
    logic [7:0]         temp_now;
    logic signed [15:0] turns_now;
    logic [15:0]        zero_now;
  } result_t;

  typedef struct packed {
    logic [15:0] half_turn_counts;
    logic [15:0] stale_ticks;
  } cfg_t;

endpackage

// ===== design/mfbt_table.sv =====
module mfbt_table #(
  parameter int NUM_SLOTS = 8,
  parameter int SLOT_W = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [SLOT_W-1:0]     wr_slot,
  input  mfbt_pkg::entry_t      wr_entry,
  input  logic [SLOT_W-1:0]     rd_slot,
  output mfbt_pkg::entry_t      rd_entry,
  output logic                  rd_registered
);
  import mfbt_pkg::*;

  entry_t entries [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] registered;

  // Only the registered flags need reset: an entry is fully rewritten when it
  // first registers, and nothing reads it before that.
  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= '0;
    end else if (wr_en) begin
      registered[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_slot] <= wr_entry;
    end
  end

  assign rd_entry = entries[rd_slot];
  assign rd_registered = registered[rd_slot];

endmodule

// ===== design/mfbt_update.sv =====
module mfbt_update #(
  parameter int MOTORS_PER_BUS = 4,
  parameter int BUSES = 2,
  parameter int SLOT_W = 3
) (
  input  mfbt_pkg::item_t       item,
  input  mfbt_pkg::cfg_t        cfg,
  input  mfbt_pkg::entry_t      rd_entry,
  input  logic                  rd_registered,
  output logic [SLOT_W-1:0]     slot,
  output logic                  wr_en,
  output mfbt_pkg::entry_t      wr_entry,
  output mfbt_pkg::result_t     result
);
  import mfbt_pkg::*;

  logic [10:0]        idx_raw;
  logic               id_ok;
  logic               stale;
  logic               reinit;
  logic [31:0]        age;
  logic signed [16:0] diff;
  logic signed [16:0] half;
  logic signed [15:0] turns_step;

  assign idx_raw = item.can_id - ID_BASE;
  assign id_ok = (item.can_id >= ID_BASE) && (32'(idx_raw) < MOTORS_PER_BUS)
                 && (32'(item.bus) < BUSES);
  assign slot = SLOT_W'(32'(item.bus) * MOTORS_PER_BUS + 32'(idx_raw));

  assign age = item.now_tick - rd_entry.stamp;
  assign stale = age > {16'd0, cfg.stale_ticks};
  assign reinit = !rd_registered || stale;

  assign diff = $signed({1'b0, item.angle_raw}) - $signed({1'b0, rd_entry.pos});
  assign half = $signed({1'b0, cfg.half_turn_counts});

  // An upward jump past half a revolution means the encoder wrapped backward.
  always_comb begin
    turns_step = rd_entry.turns;
    if (diff > half) begin
      if (rd_entry.turns != 16'sh8000) begin
        turns_step = rd_entry.turns - 16'sd1;
      end
    end else if (diff < -half) begin
      if (rd_entry.turns != 16'sh7fff) begin
        turns_step = rd_entry.turns + 16'sd1;
      end
    end
  end

  always_comb begin
    wr_entry = rd_entry;
    wr_en = 1'b0;
    if (id_ok) begin
      if (item.func == FUNC_ZERO) begin
        wr_en = rd_registered;
        wr_entry.zero = rd_entry.pos;
        wr_entry.turns = 16'sd0;
      end else begin
        wr_en = 1'b1;
        wr_entry.pos = item.angle_raw;
        wr_entry.vel = item.speed_raw;
        wr_entry.amps = item.current_raw;
        wr_entry.temp = item.temp_byte;
        wr_entry.stamp = item.now_tick;
        wr_entry.turns = reinit ? 16'sd0 : turns_step;
        wr_entry.zero = reinit ? 16'd0 : rd_entry.zero;
      end
    end
  end

  always_comb begin
    result = '0;
    if (wr_en) begin
      result.accepted = 1'b1;
      result.motor_slot = 3'(32'(slot));
      result.was_reset = (item.func == FUNC_FEEDBACK) && reinit;
      result.pos_now = wr_entry.pos;
      result.vel_now = wr_entry.vel;
      result.amps_now = wr_entry.amps;
      result.temp_now = wr_entry.temp;
      result.turns_now = wr_entry.turns;
      result.zero_now = wr_entry.zero;
    end
  end

endmodule

// ===== design/motor_feedback_turn_tracker_top.sv =====
// Multi-turn position tracker for a table of BUSES x MOTORS_PER_BUS motors
// (eight by default). Each item on the input stream is a feedback frame or a
// zero command; it produces exactly one result item, through the input
// register and then the result register. One item is taken every clock
// cycle while the output is not stalled: the entry addressed by an item is
// read, updated and written back between the input register and the result
// register, so the next item always sees the updated entry. The table lives
// in flip-flops, and reset clears only each entry's registered flag; there
// is no clearing pass. Configuration: half_turn_counts at address 0 and
// stale_ticks at address 4, to be written only while no item is in flight.
module motor_feedback_turn_tracker_top #(
  parameter int MOTORS_PER_BUS = mfbt_pkg::MFBT_MOTORS_PER_BUS,
  parameter int BUSES = mfbt_pkg::MFBT_BUSES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // can_id[10:0], now_tick[42:11], temp_byte[50:43], current_raw[66:51],
  // speed_raw[82:67], angle_raw[98:83], zero fill[103:99]
  input  logic [103:0] s_axis_tdata,
  // func[0], bus[1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // motor_slot[2:0], pos_now[18:3], vel_now[34:19], amps_now[50:35],
  // temp_now[58:51], turns_now[74:59], zero_now[90:75], zero fill[95:91]
  output logic [95:0]  m_axis_tdata,
  // accepted[0], was_reset[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mfbt_pkg::*;

  localparam int NUM_SLOTS = BUSES * MOTORS_PER_BUS;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t out_result;
  logic    out_valid;
  logic    advance;

  logic [SLOT_W-1:0] slot;
  logic              wr_en;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic              rd_registered;
  result_t           result;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_turn_counts <= HALF_TURN_RESET;
      cfg.stale_ticks <= STALE_TICKS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HALF_TURN: cfg.half_turn_counts <= pwdata[15:0];
        REG_STALE_TICKS: cfg.stale_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HALF_TURN: prdata = {16'd0, cfg.half_turn_counts};
      REG_STALE_TICKS: prdata = {16'd0, cfg.stale_ticks};
      default: prdata = '0;
    endcase
  end

  // The entry is updated at the same edge that loads the result register.
  assign advance = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.func <= s_axis_tuser[0];
      in_item.bus <= s_axis_tuser[1];
      in_item.can_id <= s_axis_tdata[10:0];
      in_item.now_tick <= s_axis_tdata[42:11];
      in_item.temp_byte <= s_axis_tdata[50:43];
      in_item.current_raw <= s_axis_tdata[66:51];
      in_item.speed_raw <= s_axis_tdata[82:67];
      in_item.angle_raw <= s_axis_tdata[98:83];
    end
    if (advance) begin
      out_result <= result;
    end
  end

  mfbt_update #(
    .MOTORS_PER_BUS(MOTORS_PER_BUS),
    .BUSES(BUSES),
    .SLOT_W(SLOT_W)
  ) u_update (
    .item(in_item),
    .cfg(cfg),
    .rd_entry(rd_entry),
    .rd_registered(rd_registered),
    .slot(slot),
    .wr_en(wr_en),
    .wr_entry(wr_entry),
    .result(result)
  );

  mfbt_table #(
    .NUM_SLOTS(NUM_SLOTS),
    .SLOT_W(SLOT_W)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en && advance),
    .wr_slot(slot),
    .wr_entry(wr_entry),
    .rd_slot(slot),
    .rd_entry(rd_entry),
    .rd_registered(rd_registered)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser = {out_result.was_reset, out_result.accepted};
  assign m_axis_tdata = {5'd0, out_result.zero_now, out_result.turns_now,
                         out_result.temp_now, out_result.amps_now,
                         out_result.vel_now, out_result.pos_now,
                         out_result.motor_slot};

  // A rejected item carries an all-zero result.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("rejected item with nonzero result");

  // A re-initialised entry starts with no turns and no zero offset.
  a_reinit_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tuser[0] && m_axis_tdata[90:59] == '0))
    else $error("re-initialised entry not cleared");

  // With the result register empty the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An item accepted while the output is empty always leads to a valid output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted item");

endmodule

// ===== bench/motor_feedback_turn_tracker_top_tb.sv =====
module motor_feedback_turn_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfbt_pkg::*;

  localparam int MOTORS = MFBT_MOTORS_PER_BUS;
  localparam int BUSES = MFBT_BUSES;
  localparam int SLOTS = MOTORS * BUSES;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 2000;
  localparam int SAT_PAIRS = 8;
  localparam int REPORT_CAP = 100;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // can_id[10:0], now_tick[42:11], temp_byte[50:43], current_raw[66:51],
  // speed_raw[82:67], angle_raw[98:83], zero fill[103:99]
  logic [103:0] s_axis_tdata;
  // func[0], bus[1]
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // motor_slot[2:0], pos_now[18:3], vel_now[34:19], amps_now[50:35],
  // temp_now[58:51], turns_now[74:59], zero_now[90:75], zero fill[95:91]
  logic [95:0]  m_axis_tdata;
  // accepted[0], was_reset[1]
  logic [1:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  item_t   drv_item = '0;
  item_t   frame_queue[$];
  result_t expect_q[$];
  logic    in_taken = 1'b0;
  int      idle_pct = 35;
  int      mismatch_count = 0;
  logic    hold_req = 1'b0;
  logic    hold_ack = 1'b0;
  int      hold_left = 0;

  // Predicted state of the motor table and the configuration.
  cfg_t        cfg;
  entry_t      motor_entry [SLOTS];
  logic        slot_live [SLOTS];
  // Stimulus-side view of each slot, used to aim ages and angle jumps.
  logic [31:0] gen_stamp [SLOTS];
  logic [15:0] gen_angle [SLOTS];

  motor_feedback_turn_tracker_top DUT (.*);

  assign s_axis_tdata = {5'b0, drv_item.angle_raw, drv_item.speed_raw, drv_item.current_raw,
                         drv_item.temp_byte, drv_item.now_tick, drv_item.can_id};
  assign s_axis_tuser = {drv_item.bus, drv_item.func};

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic result_t track_frame(input item_t it);
    result_t     res;
    int unsigned idx;
    int unsigned slot;
    logic [31:0] age;
    int          ang_new;
    int          ang_old;
    int          half;
    int          turns;
    res = '0;
    if (it.can_id < ID_BASE) return res;
    idx = 32'(it.can_id - ID_BASE);
    if (idx >= MOTORS || 32'(it.bus) >= BUSES) return res;
    slot = 32'(it.bus) * MOTORS + idx;
    if (it.func == FUNC_ZERO) begin
      // A zero command only acts on an entry that has seen a frame.
      if (!slot_live[slot]) return res;
      motor_entry[slot].zero = motor_entry[slot].pos;
      motor_entry[slot].turns = '0;
    end else begin
      age = it.now_tick - motor_entry[slot].stamp;
      if (!slot_live[slot] || age > 32'(cfg.stale_ticks)) begin
        motor_entry[slot] = '0;
        slot_live[slot] = 1'b1;
        res.was_reset = 1'b1;
      end else begin
        ang_new = int'(it.angle_raw);
        ang_old = int'(motor_entry[slot].pos);
        half = int'(cfg.half_turn_counts);
        turns = int'(motor_entry[slot].turns);
        if (ang_new - ang_old > half) begin
          if (turns > -32768) turns--;
        end else if (ang_new - ang_old < -half) begin
          if (turns < 32767) turns++;
        end
        motor_entry[slot].turns = turns[15:0];
      end
      motor_entry[slot].pos = it.angle_raw;
      motor_entry[slot].vel = it.speed_raw;
      motor_entry[slot].amps = it.current_raw;
      motor_entry[slot].temp = it.temp_byte;
      motor_entry[slot].stamp = it.now_tick;
    end
    res.accepted = 1'b1;
    res.motor_slot = slot[2:0];
    res.pos_now = motor_entry[slot].pos;
    res.vel_now = motor_entry[slot].vel;
    res.amps_now = motor_entry[slot].amps;
    res.temp_now = motor_entry[slot].temp;
    res.turns_now = motor_entry[slot].turns;
    res.zero_now = motor_entry[slot].zero;
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      if (mismatch_count < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, seen);
      mismatch_count++;
    end
  endtask

  task automatic compare_result(input result_t want, input result_t seen);
    check_field("accepted", int'(want.accepted), int'(seen.accepted));
    check_field("motor_slot", int'(want.motor_slot), int'(seen.motor_slot));
    check_field("was_reset", int'(want.was_reset), int'(seen.was_reset));
    check_field("pos_now", int'(want.pos_now), int'(seen.pos_now));
    check_field("vel_now", int'(want.vel_now), int'(seen.vel_now));
    check_field("amps_now", int'(want.amps_now), int'(seen.amps_now));
    check_field("temp_now", int'(want.temp_now), int'(seen.temp_now));
    check_field("turns_now", int'(want.turns_now), int'(seen.turns_now));
    check_field("zero_now", int'(want.zero_now), int'(seen.zero_now));
  endtask

  // Input driver: holds an item until it is taken, then offers the next one.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (frame_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drv_item <= frame_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready, with a long hold-off counted here when the stimulus requests one.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    result_t seen;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) expect_q.push_back(track_frame(drv_item));
      if (m_axis_tvalid && m_axis_tready) begin
        seen.accepted = m_axis_tuser[0];
        seen.was_reset = m_axis_tuser[1];
        seen.motor_slot = m_axis_tdata[2:0];
        seen.pos_now = m_axis_tdata[18:3];
        seen.vel_now = m_axis_tdata[34:19];
        seen.amps_now = m_axis_tdata[50:35];
        seen.temp_now = m_axis_tdata[58:51];
        seen.turns_now = m_axis_tdata[74:59];
        seen.zero_now = m_axis_tdata[90:75];
        if (expect_q.size() == 0) begin
          if (mismatch_count < REPORT_CAP) $error("result item with no item outstanding");
          mismatch_count++;
        end else begin
          compare_result(expect_q.pop_front(), seen);
        end
      end
    end
  end

  task automatic apb_write(input logic reg_sel, input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_HALF_TURN) cfg.half_turn_counts = value;
    else cfg.stale_ticks = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] half, input logic [15:0] stale);
    apb_write(REG_HALF_TURN, half);
    apb_write(REG_STALE_TICKS, stale);
  endtask

  // Waits until every queued item is taken and every result has come back.
  task automatic drain();
    int waited;
    waited = 0;
    do @(posedge clk); while (frame_queue.size() != 0 || s_axis_tvalid);
    while (expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expect_q.size() != 0) begin
      $error("%0d result items never arrived", expect_q.size());
      mismatch_count++;
      expect_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_item(input logic func, input logic bus, input logic [10:0] id,
                            input logic [31:0] now, input logic [7:0] temp,
                            input logic [15:0] amps, input logic [15:0] vel,
                            input logic [15:0] pos);
    item_t       it;
    int unsigned slot;
    it.func = func;
    it.bus = bus;
    it.can_id = id;
    it.now_tick = now;
    it.temp_byte = temp;
    it.current_raw = amps;
    it.speed_raw = vel;
    it.angle_raw = pos;
    frame_queue.push_back(it);
    if (func == FUNC_FEEDBACK && id >= ID_BASE && 32'(id - ID_BASE) < MOTORS) begin
      slot = 32'(bus) * MOTORS + 32'(id - ID_BASE);
      gen_stamp[slot] = now;
      gen_angle[slot] = pos;
    end
  endtask

  task automatic queue_random_item();
    int unsigned r;
    logic        bus;
    logic        func;
    logic [10:0] id;
    logic [10:0] offs;
    int unsigned slot;
    logic [31:0] now;
    int          half;
    int          step;
    int          target;
    bus = 1'($urandom_range(1));
    if ($urandom_range(99) < 82) begin
      id = 11'(ID_BASE + $urandom_range(MOTORS - 1));
      func = ($urandom_range(99) < 10) ? FUNC_ZERO : FUNC_FEEDBACK;
    end else begin
      case ($urandom_range(3))
        0: id = 11'(ID_BASE - 1);
        1: id = 11'(ID_BASE + MOTORS);
        default: id = 11'($urandom_range(2047));
      endcase
      func = 1'($urandom_range(1));
    end
    offs = id - ID_BASE;
    slot = 32'(bus) * MOTORS + 32'(offs) % MOTORS;

    // Age relative to the slot's last frame, with both sides of the limit.
    r = $urandom_range(99);
    if (r < 60) now = gen_stamp[slot] + $urandom_range(32'(cfg.stale_ticks));
    else if (r < 72) now = gen_stamp[slot] + 32'(cfg.stale_ticks);
    else if (r < 84) now = gen_stamp[slot] + 32'(cfg.stale_ticks) + 32'd1;
    else if (r < 92) now = gen_stamp[slot] - $urandom_range(1, 3);
    else now = $urandom;

    // Angle moves within, just past, or exactly at half a revolution, or jumps to a random angle.
    half = int'(cfg.half_turn_counts);
    r = $urandom_range(99);
    if (r < 35) step = int'($urandom_range(2 * half)) - half;
    else if (r < 55) step = half + 1 + int'($urandom_range(50));
    else if (r < 75) step = -half - 1 - int'($urandom_range(50));
    else step = $urandom_range(1) ? half : -half;
    target = int'(gen_angle[slot]);
    target += step;
    if (target < 0 || target > 65535) begin
      target = int'(gen_angle[slot]);
      target -= step;
    end
    if (r >= 85 || target < 0 || target > 65535) target = int'($urandom_range(65535));

    queue_item(func, bus, id, now, 8'($urandom), 16'($urandom), 16'($urandom),
               target[15:0]);
  endtask

  task automatic run_random(input int count);
    repeat (count) queue_random_item();
  endtask

  initial begin
    cfg.half_turn_counts = HALF_TURN_RESET;
    cfg.stale_ticks = STALE_TICKS_RESET;
    for (int s = 0; s < SLOTS; s++) begin
      motor_entry[s] = '0;
      slot_live[s] = 1'b0;
      gen_stamp[s] = '0;
      gen_angle[s] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames with the reset configuration.
    queue_item(FUNC_ZERO, 1'b0, ID_BASE, 32'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd0, 8'h00, 16'h8000, 16'h7FFF, 16'h0000);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd10, 8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd20, 8'h01, 16'hFFFF, 16'h0001, 16'h0000);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd30, 8'h80, 16'h0001, 16'hFFFF, 16'h8000);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd40, 8'h7F, 16'h1234, 16'h4321, 16'h0000);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd50, 8'h3C, 16'hABCD, 16'hDCBA, 16'h8001);
    queue_item(FUNC_ZERO, 1'b0, ID_BASE, 32'd55, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    queue_item(FUNC_FEEDBACK, 1'b0, ID_BASE, 32'd61, 8'h22, 16'h0100, 16'h0200, 16'h1234);
    queue_item(FUNC_FEEDBACK, 1'b0, 11'(ID_BASE - 1), 32'd62, 8'h11, 16'h1111, 16'h1111,
               16'h1111);
    queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + MOTORS), 32'd63, 8'h11, 16'h1111, 16'h1111,
               16'h1111);
    queue_item(FUNC_FEEDBACK, 1'b0, 11'h000, 32'd64, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(FUNC_ZERO, 1'b1, 11'h7FF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + 3), 32'hFFFF_FFF8, 8'h5A, 16'h0F0F, 16'hF0F0,
               16'h4000);
    queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + 3), 32'h0000_0002, 8'hA5, 16'hF0F0, 16'h0F0F,
               16'hC001);
    queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + 3), 32'h0000_000D, 8'h66, 16'h5555, 16'hAAAA,
               16'h0001);
    queue_item(FUNC_FEEDBACK, 1'b0, 11'(ID_BASE + 3), 32'hFFFF_FFFF, 8'h99, 16'hAAAA, 16'h5555,
               16'hFFFF);
    queue_item(FUNC_FEEDBACK, 1'b1, ID_BASE, 32'h8000_0000, 8'h42, 16'h8000, 16'h8000,
               16'h7FFF);
    queue_item(FUNC_ZERO, 1'b1, ID_BASE, 32'h8000_0001, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    queue_item(FUNC_ZERO, 1'b0, 11'(ID_BASE + 1), 32'd70, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // Smallest half turn and no tolerated age.
    set_config(16'd1, 16'd0);
    run_random(250);
    drain();

    // Largest settings, with the receiver holding off while items keep coming.
    set_config(16'd65535, 16'd65535);
    @(posedge clk);
    hold_req = ~hold_req;
    run_random(250);
    drain();

    // Reset values again, with neither side idling.
    set_config(HALF_TURN_RESET, STALE_TICKS_RESET);
    idle_pct = 0;
    run_random(250);
    drain();
    idle_pct = 35;

    set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
    run_random(300);
    drain();

    // Step one slot's turn count down and another's up. Jumps of one more
    // than half a turn alternate with returns of exactly half a turn.
    set_config(16'd16384, 16'd65535);
    queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + 2), gen_stamp[6] + 32'h1_0000,
               8'($urandom), 16'($urandom), 16'($urandom), 16'd0);
    queue_item(FUNC_FEEDBACK, 1'b0, 11'(ID_BASE + 2), gen_stamp[2] + 32'h1_0000,
               8'($urandom), 16'($urandom), 16'($urandom), 16'd65535);
    for (int k = 0; k < SAT_PAIRS; k++) begin
      queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + 2), gen_stamp[6], 8'($urandom),
                 16'($urandom), 16'($urandom), 16'(k + 16385));
      queue_item(FUNC_FEEDBACK, 1'b1, 11'(ID_BASE + 2), gen_stamp[6], 8'($urandom),
                 16'($urandom), 16'($urandom), 16'(k + 1));
      queue_item(FUNC_FEEDBACK, 1'b0, 11'(ID_BASE + 2), gen_stamp[2], 8'($urandom),
                 16'($urandom), 16'($urandom), 16'(65535 - k - 16385));
      queue_item(FUNC_FEEDBACK, 1'b0, 11'(ID_BASE + 2), gen_stamp[2], 8'($urandom),
                 16'($urandom), 16'($urandom), 16'(65534 - k));
    end
    queue_item(FUNC_ZERO, 1'b1, 11'(ID_BASE + 2), 32'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    queue_item(FUNC_ZERO, 1'b0, 11'(ID_BASE + 2), 32'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    drain();

    set_config(16'($urandom_range(100, 40000)), 16'($urandom_range(0, 40)));
    run_random(350);
    drain();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
